>>> sv/cit_pkg.sv
// shared types, constants and helpers of the connection id table
package cit_pkg;

  localparam int unsigned TableSlots = 64;
  localparam int unsigned MaxConn    = 64;

  localparam int unsigned SlotW   = $clog2(TableSlots);
  localparam int unsigned ConnW   = 6;
  localparam int unsigned ConnAw  = $clog2(MaxConn);
  localparam int unsigned SidW    = 31;
  localparam int unsigned HandleW = 32;
  localparam int unsigned PaddrW  = 3;

  typedef enum logic [1:0] {
    OpOpen   = 2'd0,
    OpClose  = 2'd1,
    OpSetFwd = 2'd2,
    OpLookup = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNotFound = 2'd1,
    StatusFull     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RouteBroker   = 2'd0,
    RouteAgent    = 2'd1,
    RouteWatchdog = 2'd2,
    RouteDrop     = 2'd3
  } route_e;

  typedef enum logic [1:0] {
    StIdle,
    StSlot,
    StConn,
    StProbe
  } state_e;

  typedef enum logic {
    RegWatchdog = 1'b0,
    RegBroker   = 1'b1
  } reg_e;

  typedef struct packed {
    logic [SidW-1:0]    session;
    logic [HandleW-1:0] agent;
    logic [HandleW-1:0] client;
  } conn_rec_t;

  function automatic logic [SidW-1:0] next_id(input logic [SidW-1:0] v);
    logic [SidW-1:0] n;
    n = v + SidW'(1);
    return (n == '0) ? SidW'(1) : n;
  endfunction

endpackage

>>> sv/cit_ram.sv
// generic single write port ram with registered read
module cit_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/connection_id_table_core.sv
// connection id table: session id allocation, close, forwarding and lookup
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-------------------------------------------
//  request  | in_valid_i / in_ready_o       | op, conn id, uid, agent/client handle
//  result   | out_valid_o / out_ready_i     | status, session_id, conn_index, route, handles
//  config   | psel penable pwrite / pready  | watchdog handle at 0x0, broker handle at 0x4
//
//  one request at a time; open of a connection that already has an id reads the connection
//  memory only, close, set forward and lookup read the slot memory, then the connection memory
//  a new id is then found by probing candidate slots one by one, up to all 64 when the table is full
//  reset clears slot and connection valid bits at once, no clearing pass is needed
//  a held result stalls the finishing cycle; the next request is taken once it is stored
module connection_id_table_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic [cit_pkg::ConnW-1:0]    conn_id_i,
  input  logic [cit_pkg::SidW-1:0]     uid_i,
  input  logic [cit_pkg::HandleW-1:0]  agent_handle_i,
  input  logic [cit_pkg::HandleW-1:0]  client_handle_i,

  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [cit_pkg::SidW-1:0]     session_id_o,
  output logic [cit_pkg::ConnW-1:0]    conn_index_o,
  output logic [1:0]                   route_o,
  output logic [cit_pkg::HandleW-1:0]  dest_handle_o,
  output logic [cit_pkg::HandleW-1:0]  source_handle_o,

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cit_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import cit_pkg::*;

  state_e state_q, state_d;

  op_e                op_q;
  logic [ConnW-1:0]   cid_q;
  logic [SidW-1:0]    uid_q;
  logic [HandleW-1:0] ah_q, ch_q;

  logic [TableSlots-1:0] slot_valid_q;
  logic [MaxConn-1:0]    sess_v_q, fwd_v_q;
  logic [SidW-1:0]       id_counter_q;
  logic [HandleW-1:0]    watchdog_q, broker_q;

  logic              hit_q;
  logic [ConnW-1:0]  c_q;
  conn_rec_t         rec_q;
  logic [SidW-1:0]   cand_q;
  logic [SlotW-1:0]  probe_cnt_q;

  logic               out_valid_q;
  logic [1:0]         status_q, route_q;
  logic [SidW-1:0]    sid_q;
  logic [ConnW-1:0]   cidx_q;
  logic [HandleW-1:0] dest_q, src_q;

  // memory ports
  logic [SlotW-1:0]  slot_raddr, slot_waddr;
  logic [ConnW-1:0]  slot_rdata;
  logic              slot_we;
  logic [ConnAw-1:0] conn_raddr, conn_idx;
  conn_rec_t         conn_rdata, conn_wdata, rec_eff;
  logic              conn_we;

  // control
  logic              out_free, fin, found, cid_ok, alloc, probe_start, probe_step;
  logic              clr_sess, set_fwd, clr_slot;
  logic [SlotW-1:0]  uid_slot, probe_slot;
  status_e           res_status;
  route_e            res_route;
  logic [SidW-1:0]   res_sid;
  logic [ConnW-1:0]  res_cidx;
  logic [HandleW-1:0] res_dest, res_src;
  logic              cfg_we;

  cit_ram #(
    .Width(ConnW),
    .Depth(TableSlots)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(cid_q),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  cit_ram #(
    .Width($bits(conn_rec_t)),
    .Depth(MaxConn)
  ) u_conn_ram (
    .clk_i  (clk_i),
    .we_i   (conn_we),
    .waddr_i(conn_idx),
    .wdata_i(conn_wdata),
    .raddr_i(conn_raddr),
    .rdata_o(conn_rdata)
  );

  assign in_ready_o = (state_q == StIdle);
  assign out_free   = !out_valid_q || out_ready_i;
  assign uid_slot   = uid_q[SlotW-1:0];
  assign probe_slot = cand_q[SlotW-1:0];
  assign slot_raddr = uid_i[SlotW-1:0];
  assign slot_waddr = probe_slot;
  // hold the entry address while a result waits
  assign conn_raddr = (state_q == StIdle) ? conn_id_i[ConnAw-1:0] :
                      (state_q == StSlot) ? slot_rdata[ConnAw-1:0] : conn_idx;
  assign conn_idx   = (op_q == OpOpen) ? cid_q[ConnAw-1:0] : c_q[ConnAw-1:0];
  assign cid_ok     = ({1'b0, cid_q} < (ConnW+1)'(MaxConn));

  always_comb begin
    rec_eff.session = sess_v_q[conn_idx] ? conn_rdata.session : '0;
    rec_eff.agent   = fwd_v_q[conn_idx]  ? conn_rdata.agent   : '0;
    rec_eff.client  = fwd_v_q[conn_idx]  ? conn_rdata.client  : '0;
  end

  assign found = hit_q && (rec_eff.session == uid_q);

  always_comb begin
    state_d     = state_q;
    fin         = 1'b0;
    res_status  = StatusNotFound;
    res_sid     = uid_q;
    res_cidx    = '0;
    res_route   = RouteBroker;
    res_dest    = '0;
    res_src     = '0;
    conn_we     = 1'b0;
    conn_wdata  = rec_eff;
    slot_we     = 1'b0;
    alloc       = 1'b0;
    probe_start = 1'b0;
    probe_step  = 1'b0;
    clr_sess    = 1'b0;
    set_fwd     = 1'b0;
    clr_slot    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = (op_i == OpOpen) ? StConn : StSlot;
        end
      end
      StSlot: begin
        state_d = StConn;
      end
      StConn: begin
        if (out_free) begin
          if (op_q == OpOpen) begin
            res_sid = '0;
            if (!cid_ok) begin
              fin = 1'b1;
            end else if (sess_v_q[conn_idx]) begin
              fin        = 1'b1;
              res_status = StatusOk;
              res_sid    = rec_eff.session;
              res_cidx   = cid_q;
            end else begin
              probe_start = 1'b1;
            end
          end else begin
            fin = 1'b1;
            if (found) begin
              res_status = StatusOk;
              res_cidx   = c_q;
            end
            unique case (op_q)
              OpClose: begin
                if (found) begin
                  conn_we          = 1'b1;
                  conn_wdata.agent = '0;
                  clr_sess         = 1'b1;
                  set_fwd          = 1'b1;
                  clr_slot         = 1'b1;
                end
              end
              OpSetFwd: begin
                if (found) begin
                  conn_we           = 1'b1;
                  conn_wdata.agent  = ah_q;
                  conn_wdata.client = ch_q;
                  set_fwd           = 1'b1;
                end
              end
              default: begin
                priority if (broker_q != '0) begin
                  res_route = RouteBroker;
                  res_dest  = broker_q;
                end else if (!found) begin
                  res_route = RouteDrop;
                end else if (rec_eff.agent != '0) begin
                  res_route = RouteAgent;
                  res_dest  = rec_eff.agent;
                  res_src   = rec_eff.client;
                end else if (watchdog_q != '0) begin
                  res_route = RouteWatchdog;
                  res_dest  = watchdog_q;
                end else begin
                  res_route = RouteDrop;
                end
              end
            endcase
          end
          state_d = fin ? StIdle : StProbe;
        end
      end
      StProbe: begin
        if (out_free) begin
          res_sid  = '0;
          res_cidx = cid_q;
          if (!slot_valid_q[probe_slot]) begin
            fin                = 1'b1;
            res_status         = StatusOk;
            res_sid            = cand_q;
            slot_we            = 1'b1;
            conn_we            = 1'b1;
            conn_wdata         = rec_q;
            conn_wdata.session = cand_q;
            set_fwd            = 1'b1;
            alloc              = 1'b1;
            state_d            = StIdle;
          end else if (probe_cnt_q == SlotW'(TableSlots - 1)) begin
            fin        = 1'b1;
            res_status = StatusFull;
            state_d    = StIdle;
          end else begin
            probe_step = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      sess_v_q     <= '0;
      fwd_v_q      <= '0;
      id_counter_q <= '0;
    end else begin
      if (alloc) begin
        slot_valid_q[probe_slot] <= 1'b1;
        sess_v_q[conn_idx]       <= 1'b1;
        id_counter_q             <= cand_q;
      end
      if (clr_slot) begin
        slot_valid_q[uid_slot] <= 1'b0;
      end
      if (clr_sess) begin
        sess_v_q[conn_idx] <= 1'b0;
      end
      if (set_fwd) begin
        fwd_v_q[conn_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= op_e'(op_i);
      cid_q <= conn_id_i;
      uid_q <= uid_i;
      ah_q  <= agent_handle_i;
      ch_q  <= client_handle_i;
    end
    if (state_q == StSlot) begin
      c_q   <= slot_rdata;
      hit_q <= slot_valid_q[uid_slot] && ({1'b0, slot_rdata} < (ConnW+1)'(MaxConn));
    end
    if (probe_start) begin
      rec_q       <= rec_eff;
      cand_q      <= next_id(id_counter_q);
      probe_cnt_q <= '0;
    end else if (probe_step) begin
      cand_q      <= next_id(cand_q);
      probe_cnt_q <= probe_cnt_q + SlotW'(1);
    end
    if (fin) begin
      status_q <= res_status;
      sid_q    <= res_sid;
      cidx_q   <= res_cidx;
      route_q  <= res_route;
      dest_q   <= res_dest;
      src_q    <= res_src;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign session_id_o    = sid_q;
  assign conn_index_o    = cidx_q;
  assign route_o         = route_q;
  assign dest_handle_o   = dest_q;
  assign source_handle_o = src_q;

  // register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watchdog_q <= '0;
      broker_q   <= '0;
    end else if (cfg_we) begin
      unique case (reg_e'(paddr[2]))
        RegWatchdog: watchdog_q <= pwdata;
        RegBroker:   broker_q   <= pwdata;
        default:     watchdog_q <= watchdog_q;
      endcase
    end
  end

  assign prdata = (reg_e'(paddr[2]) == RegBroker) ? broker_q : watchdog_q;

  // the number of valid slots equals the number of connections holding an id
  a_slot_sess_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(slot_valid_q) == $countones(sess_v_q))
    else $error("slot and session valid counts differ");

  a_cand_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StProbe) |-> (cand_q != '0))
    else $error("probe candidate id is zero");

  a_alloc_marks_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc |=> slot_valid_q[$past(probe_slot)])
    else $error("allocated slot not marked valid");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != StIdle))
    else $error("request accepted but sequencer stayed idle");

endmodule

>>> dv/tb_connection_id_table_core.sv
// testbench of the connection id table core: directed and random requests checked against a predictor
module tb_connection_id_table_core;
  import cit_pkg::*;

  typedef struct {
    status_e              status;
    logic [SidW-1:0]      session;
    logic [ConnW-1:0]     conn;
    route_e               route;
    logic [HandleW-1:0]   dest;
    logic [HandleW-1:0]   src;
  } reply_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           req_op;
  logic [ConnW-1:0]     req_cid;
  logic [SidW-1:0]      req_uid;
  logic [HandleW-1:0]   req_agent;
  logic [HandleW-1:0]   req_client;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           rsp_status;
  logic [SidW-1:0]      rsp_session;
  logic [ConnW-1:0]     rsp_conn;
  logic [1:0]           rsp_route;
  logic [HandleW-1:0]   rsp_dest;
  logic [HandleW-1:0]   rsp_src;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PaddrW-1:0]    paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  // predicted table contents
  bit                   slot_used [TableSlots];
  bit [ConnW-1:0]       slot_owner [TableSlots];
  bit [SidW-1:0]        conn_sid [MaxConn];
  bit [HandleW-1:0]     conn_agent_h [MaxConn];
  bit [HandleW-1:0]     conn_client_h [MaxConn];
  bit [SidW-1:0]        last_id;
  bit [HandleW-1:0]     wd_handle;
  bit [HandleW-1:0]     brk_handle;

  reply_t               pending_replies [$];
  int unsigned          mismatch_count;
  int unsigned          send_idle_pct;
  int unsigned          recv_idle_pct;

  connection_id_table_core uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (req_op),
    .conn_id_i       (req_cid),
    .uid_i           (req_uid),
    .agent_handle_i  (req_agent),
    .client_handle_i (req_client),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (rsp_status),
    .session_id_o    (rsp_session),
    .conn_index_o    (rsp_conn),
    .route_o         (rsp_route),
    .dest_handle_o   (rsp_dest),
    .source_handle_o (rsp_src),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic bit [SidW-1:0] advance_id(input bit [SidW-1:0] v);
    bit [SidW-1:0] n;
    n = v + 1'b1;
    return (n == '0) ? SidW'(1) : n;
  endfunction

  function automatic reply_t predict_table_op(input op_e kind, input logic [ConnW-1:0] cid,
                                              input logic [SidW-1:0] uid,
                                              input logic [HandleW-1:0] ah,
                                              input logic [HandleW-1:0] ch);
    reply_t          r;
    bit [SidW-1:0]   cand;
    bit [ConnW-1:0]  owner;
    int unsigned     slot;
    int unsigned     i;
    bit              hit;
    r.status  = StatusNotFound;
    r.session = uid;
    r.conn    = '0;
    r.route   = RouteBroker;
    r.dest    = '0;
    r.src     = '0;
    slot  = uid % TableSlots;
    owner = slot_owner[slot];
    hit   = slot_used[slot] && (int'(owner) < MaxConn) && (conn_sid[owner] == uid);
    case (kind)
      OpOpen: begin
        r.session = '0;
        if (int'(cid) < MaxConn) begin
          r.conn = cid;
          if (conn_sid[cid] != '0) begin
            r.status  = StatusOk;
            r.session = conn_sid[cid];
          end else begin
            r.status = StatusFull;
            cand = advance_id(last_id);
            for (i = 0; i < TableSlots; i++) begin
              slot = cand % TableSlots;
              if (!slot_used[slot]) begin
                slot_used[slot]  = 1'b1;
                slot_owner[slot] = cid;
                conn_sid[cid]    = cand;
                last_id          = cand;
                r.session        = cand;
                r.status         = StatusOk;
                break;
              end
              cand = advance_id(cand);
            end
          end
        end
      end
      OpClose: begin
        if (hit) begin
          conn_sid[owner]     = '0;
          conn_agent_h[owner] = '0;
          slot_used[slot]     = 1'b0;
          r.status = StatusOk;
          r.conn   = owner;
        end
      end
      OpSetFwd: begin
        if (hit) begin
          conn_agent_h[owner]  = ah;
          conn_client_h[owner] = ch;
          r.status = StatusOk;
          r.conn   = owner;
        end
      end
      default: begin
        if (hit) begin
          r.status = StatusOk;
          r.conn   = owner;
        end
        if (brk_handle != '0) begin
          r.route = RouteBroker;
          r.dest  = brk_handle;
        end else if (!hit) begin
          r.route = RouteDrop;
        end else if (conn_agent_h[owner] != '0) begin
          r.route = RouteAgent;
          r.dest  = conn_agent_h[owner];
          r.src   = conn_client_h[owner];
        end else if (wd_handle != '0) begin
          r.route = RouteWatchdog;
          r.dest  = wd_handle;
        end else begin
          r.route = RouteDrop;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: status %0d session %0h", rsp_status, rsp_session);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        if (rsp_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_status);
          mismatch_count++;
        end
        if (rsp_session !== want.session) begin
          $error("session_id: expected %0h, got %0h", want.session, rsp_session);
          mismatch_count++;
        end
        if (rsp_conn !== want.conn) begin
          $error("conn_index: expected %0d, got %0d", want.conn, rsp_conn);
          mismatch_count++;
        end
        if (rsp_route !== want.route) begin
          $error("route: expected %0d, got %0d", want.route, rsp_route);
          mismatch_count++;
        end
        if (rsp_dest !== want.dest) begin
          $error("dest_handle: expected %0h, got %0h", want.dest, rsp_dest);
          mismatch_count++;
        end
        if (rsp_src !== want.src) begin
          $error("source_handle: expected %0h, got %0h", want.src, rsp_src);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_request(input op_e kind, input logic [ConnW-1:0] cid,
                              input logic [SidW-1:0] uid, input logic [HandleW-1:0] ah,
                              input logic [HandleW-1:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_op     <= kind;
    req_cid    <= cid;
    req_uid    <= uid;
    req_agent  <= ah;
    req_client <= ch;
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(predict_table_op(kind, cid, uid, ah, ch));
  endtask

  task automatic wait_table_idle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegWatchdog) wd_handle = value;
    else brk_handle = value;
    @(posedge clk);
  endtask

  task automatic set_handles(input logic [31:0] wd, input logic [31:0] brk);
    wait_table_idle();
    write_reg(RegWatchdog, wd);
    write_reg(RegBroker, brk);
  endtask

  function automatic logic [SidW-1:0] pick_uid();
    logic [SidW-1:0] live [$];
    int unsigned     r;
    int unsigned     i;
    for (i = 0; i < MaxConn; i++) begin
      if (conn_sid[i] != '0) live.push_back(conn_sid[i]);
    end
    r = $urandom_range(99);
    if (live.size() != 0 && r < 70) return live[$urandom_range(live.size() - 1)];
    // same slot, other id
    if (live.size() != 0 && r < 80)
      return live[$urandom_range(live.size() - 1)] + SidW'(TableSlots * $urandom_range(1, 8));
    // most likely a retired id
    if (r < 90) return last_id - SidW'($urandom_range(80));
    return SidW'($urandom());
  endfunction

  task automatic random_traffic(input int unsigned count, input int unsigned open_pct);
    int unsigned          k;
    op_e                  kind;
    logic [HandleW-1:0]   ah;
    for (k = 0; k < count; k++) begin
      kind = ($urandom_range(99) < open_pct) ? OpOpen : op_e'($urandom_range(3, 1));
      ah   = ($urandom_range(3) == 0) ? '0 : HandleW'($urandom());
      send_request(kind, ConnW'($urandom_range(MaxConn - 1)), pick_uid(), ah,
                   HandleW'($urandom()));
    end
  endtask

  task automatic test_directed_ops();
    set_handles(32'h0, 32'h0);
    send_request(OpLookup, 6'd0, 31'd0, 32'h0, 32'h0);
    send_request(OpLookup, 6'd63, 31'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OpClose, 6'd0, 31'd5, 32'h0, 32'h0);
    send_request(OpSetFwd, 6'd0, 31'd5, 32'h1, 32'h2);
    send_request(OpOpen, 6'd0, 31'd0, 32'h0, 32'h0);
    send_request(OpOpen, 6'd63, 31'h7fff_ffff, 32'h0, 32'h0);
    send_request(OpOpen, 6'd0, 31'd0, 32'h0, 32'h0);
    send_request(OpSetFwd, 6'd0, 31'd1, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OpLookup, 6'd0, 31'd1, 32'h0, 32'h0);
    send_request(OpLookup, 6'd0, 31'd2, 32'h0, 32'h0);
    send_request(OpLookup, 6'd0, 31'd65, 32'h0, 32'h0);
    send_request(OpClose, 6'd0, 31'd65, 32'h0, 32'h0);
    send_request(OpClose, 6'd0, 31'd1, 32'h0, 32'h0);
    send_request(OpLookup, 6'd0, 31'd1, 32'h0, 32'h0);
    send_request(OpOpen, 6'd0, 31'd0, 32'h0, 32'h0);
    send_request(OpSetFwd, 6'd0, 31'd3, 32'h0, 32'h5a5a_5a5a);
    send_request(OpClose, 6'd0, 31'd2, 32'h0, 32'h0);
    send_request(OpClose, 6'd0, 31'd2, 32'h0, 32'h0);
  endtask

  task automatic test_route_config();
    set_handles(32'hffff_ffff, 32'h0);
    send_request(OpLookup, 6'd0, 31'd3, 32'h0, 32'h0);
    send_request(OpLookup, 6'd0, 31'd999, 32'h0, 32'h0);
    set_handles(32'hffff_ffff, 32'hffff_ffff);
    send_request(OpLookup, 6'd0, 31'd3, 32'h0, 32'h0);
    send_request(OpLookup, 6'd0, 31'd999, 32'h0, 32'h0);
    send_request(OpOpen, 6'd63, 31'd0, 32'h0, 32'h0);
    set_handles(32'h0, 32'h0);
  endtask

  task automatic test_fill_table();
    int unsigned i;
    for (i = 0; i < MaxConn; i++) begin
      send_request(OpOpen, ConnW'((i * 37) % MaxConn), SidW'($urandom()), HandleW'($urandom()),
                   HandleW'($urandom()));
    end
    random_traffic(60, 60);
  endtask

  task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_handles(32'h0, 32'h0);
    random_traffic(80, 35);
    set_handles($urandom() | 32'h1, 32'h0);
    random_traffic(80, 35);
    set_handles(32'hffff_ffff, 32'h0);
    random_traffic(80, 35);
    set_handles($urandom(), $urandom() | 32'h1);
    random_traffic(20, 35);
    set_handles(32'h0, 32'h0);
  endtask

  initial begin
    #12000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    out_ready      = 1'b0;
    req_op         = OpOpen;
    req_cid        = '0;
    req_uid        = '0;
    req_agent      = '0;
    req_client     = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    send_idle_pct  = 34;
    recv_idle_pct  = 86;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_route_config();
    test_random_phase(34, 86);
    test_random_phase(86, 34);
    test_fill_table();
    test_random_phase(0, 0);

    wait_table_idle();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
